/* sv/dtfp_pkg.sv */
// Shared types, constants and lookup functions for the decimal text to fixed-point converter.
`timescale 1ns / 1ps

package dtfp_pkg;

	// Field widths
	localparam int CHAR_W  = 8;
	localparam int POWER_W = 4;
	localparam int MAG_W   = 31;
	localparam int VALUE_W = 32;
	localparam int POW10_W = 30;
	// Magnitude times ten plus a digit needs four more bits than the magnitude.
	localparam int TMP_W   = MAG_W + 4;

	localparam logic [POWER_W-1:0] RESET_SCALE = 4'd7;
	localparam logic [MAG_W-1:0]   MAX_MAG     = 31'h7FFF_FFFF;

	// Characters the parser recognises
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;

	// Smallest digit that rounds the magnitude up.
	localparam logic [3:0] ROUND_DIGIT = 4'd5;

	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_DIGITS = 2'd1,
		PH_ROUND  = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	// Parser state that the scaling stage reads when the number ends.
	typedef struct packed {
		logic [MAG_W-1:0]   magnitude;
		logic [POWER_W-1:0] power_left;
		logic               is_negative;
	} parse_state_t;

	// Ten to the power p; powers of ten or more, which saturate any nonzero magnitude, return zero.
	function automatic logic [POW10_W-1:0] pow10(input logic [POWER_W-1:0] p);
		logic [POW10_W-1:0] r;
		case (p)
			4'd0:    r = 30'd1;
			4'd1:    r = 30'd10;
			4'd2:    r = 30'd100;
			4'd3:    r = 30'd1000;
			4'd4:    r = 30'd10000;
			4'd5:    r = 30'd100000;
			4'd6:    r = 30'd1000000;
			4'd7:    r = 30'd10000000;
			4'd8:    r = 30'd100000000;
			4'd9:    r = 30'd1000000000;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Largest value that, times ten to the power p, still fits in MAX_MAG.
	function automatic logic [MAG_W-1:0] fit_limit(input logic [POWER_W-1:0] p);
		logic [MAG_W-1:0] r;
		case (p)
			4'd0:    r = 31'd2147483647;
			4'd1:    r = 31'd214748364;
			4'd2:    r = 31'd21474836;
			4'd3:    r = 31'd2147483;
			4'd4:    r = 31'd214748;
			4'd5:    r = 31'd21474;
			4'd6:    r = 31'd2147;
			4'd7:    r = 31'd214;
			4'd8:    r = 31'd21;
			4'd9:    r = 31'd2;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* sv/dtfp_parse.sv */
// Character parser: holds the scale register and the per-number parse state.
`timescale 1ns / 1ps

module dtfp_parse (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dtfp_pkg::POWER_W-1:0]  cfg_wdata,
	input  logic                          char_fire,
	input  logic [dtfp_pkg::CHAR_W-1:0]   char_in,
	output dtfp_pkg::parse_state_t        state
);

	logic [dtfp_pkg::POWER_W-1:0] scale_power_q;
	dtfp_pkg::phase_t             phase_q, phase_d;
	logic [dtfp_pkg::MAG_W-1:0]   mag_q, mag_d;
	logic [dtfp_pkg::POWER_W-1:0] power_q, power_d;
	logic                         frac_q, frac_d;
	logic                         neg_q, neg_d;

	logic                         is_digit;
	logic [3:0]                   digit;
	logic                         round_up;
	logic [dtfp_pkg::POWER_W-1:0] p_base;
	logic [dtfp_pkg::POWER_W-1:0] p_new;
	logic                         p_used;
	logic [dtfp_pkg::TMP_W-1:0]   tmp;
	logic                         fits;
	logic [dtfp_pkg::MAG_W-1:0]   mag_fail;
	dtfp_pkg::phase_t             take_phase;
	logic [dtfp_pkg::MAG_W-1:0]   take_mag;
	logic [dtfp_pkg::POWER_W-1:0] take_power;

	// Scale register; a number picks up its value with its first sign or digit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_power_q <= dtfp_pkg::RESET_SCALE;
		end else if (cfg_we) begin
			scale_power_q <= cfg_wdata;
		end
	end

	// Digit decode and the fit check for taking one more digit.
	always_comb begin
		is_digit = (char_in >= dtfp_pkg::CH_ZERO) && (char_in <= dtfp_pkg::CH_NINE);
		digit    = is_digit ? 4'(char_in - dtfp_pkg::CH_ZERO) : 4'd0;
		round_up = is_digit && (digit >= dtfp_pkg::ROUND_DIGIT);

		// The power is loaded from the register with the first sign or digit of a number.
		p_base = (phase_q == dtfp_pkg::PH_SKIP) ? scale_power_q : power_q;
		if (frac_q) begin
			p_new  = (p_base == '0) ? '0 : p_base - 1'b1;
			p_used = (p_base <= 4'd1);
		end else begin
			p_new  = p_base;
			p_used = (p_base == '0);
		end

		tmp  = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0}
		       + {{(dtfp_pkg::TMP_W-4){1'b0}}, digit};
		fits = tmp <= {4'b0000, dtfp_pkg::fit_limit(p_new)};

		// A digit that does not fit ends the parse; a fraction digit may round.
		mag_fail = frac_q ? mag_q : dtfp_pkg::MAX_MAG;
		if (round_up && (mag_fail != dtfp_pkg::MAX_MAG)) begin
			mag_fail = mag_fail + 1'b1;
		end

		if (fits) begin
			take_mag   = tmp[dtfp_pkg::MAG_W-1:0];
			take_power = p_new;
			take_phase = p_used ? dtfp_pkg::PH_ROUND : dtfp_pkg::PH_DIGITS;
		end else begin
			take_mag   = mag_fail;
			take_power = p_base;
			take_phase = dtfp_pkg::PH_DONE;
		end
	end

	// Next parse state for one character.
	always_comb begin
		phase_d = phase_q;
		mag_d   = mag_q;
		power_d = power_q;
		frac_d  = frac_q;
		neg_d   = neg_q;
		if (char_in == dtfp_pkg::CH_NUL) begin
			phase_d = dtfp_pkg::PH_SKIP;
			mag_d   = '0;
			power_d = scale_power_q;
			frac_d  = 1'b0;
			neg_d   = 1'b0;
		end else begin
			case (phase_q)
				dtfp_pkg::PH_SKIP: begin
					if (is_digit) begin
						phase_d = take_phase;
						mag_d   = take_mag;
						power_d = take_power;
					end else if (char_in == dtfp_pkg::CH_MINUS) begin
						power_d = scale_power_q;
						neg_d   = 1'b1;
						phase_d = dtfp_pkg::PH_DIGITS;
					end else if (char_in == dtfp_pkg::CH_PLUS) begin
						power_d = scale_power_q;
						phase_d = dtfp_pkg::PH_DONE;
					end
				end
				dtfp_pkg::PH_DIGITS: begin
					if (is_digit) begin
						phase_d = take_phase;
						mag_d   = take_mag;
						power_d = take_power;
					end else if (char_in == dtfp_pkg::CH_POINT) begin
						frac_d = 1'b1;
					end else begin
						phase_d = dtfp_pkg::PH_DONE;
					end
				end
				dtfp_pkg::PH_ROUND: begin
					if (round_up && (mag_q != dtfp_pkg::MAX_MAG)) begin
						mag_d = mag_q + 1'b1;
					end
					phase_d = dtfp_pkg::PH_DONE;
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	// Parse state registers, updated on every accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dtfp_pkg::PH_SKIP;
			mag_q   <= '0;
			power_q <= dtfp_pkg::RESET_SCALE;
			frac_q  <= 1'b0;
			neg_q   <= 1'b0;
		end else if (char_fire) begin
			phase_q <= phase_d;
			mag_q   <= mag_d;
			power_q <= power_d;
			frac_q  <= frac_d;
			neg_q   <= neg_d;
		end
	end

	assign state.magnitude   = mag_q;
	assign state.power_left  = power_q;
	assign state.is_negative = neg_q;

endmodule

/* sv/dtfp_scale.sv */
// Final scaling, saturation and sign, with the result register and its handshake.
`timescale 1ns / 1ps

module dtfp_scale (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  dtfp_pkg::parse_state_t        state,
	input  logic                          m_tready,
	output logic                          m_tvalid,
	output logic [dtfp_pkg::VALUE_W-1:0]  m_tdata
);

	localparam int PROD_W = dtfp_pkg::MAG_W + dtfp_pkg::POW10_W;

	logic [PROD_W-1:0]             product;
	logic                          saturate;
	logic [dtfp_pkg::MAG_W-1:0]    mag_out;
	logic [dtfp_pkg::VALUE_W-1:0]  value;
	logic                          valid_q;
	logic [dtfp_pkg::VALUE_W-1:0]  data_q;

	// Magnitude times ten to the remaining power, saturated, then signed.
	always_comb begin
		product  = {{dtfp_pkg::POW10_W{1'b0}}, state.magnitude}
		           * {{dtfp_pkg::MAG_W{1'b0}}, dtfp_pkg::pow10(state.power_left)};
		saturate = state.magnitude > dtfp_pkg::fit_limit(state.power_left);
		mag_out  = saturate ? dtfp_pkg::MAX_MAG : product[dtfp_pkg::MAG_W-1:0];
		value    = state.is_negative ? (32'd0 - {1'b0, mag_out}) : {1'b0, mag_out};
	end

	// Result register: valid held until the item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= value;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

endmodule

/* sv/decimal_text_to_fixed_point.sv */
// Top level of the decimal text to fixed-point converter.
`timescale 1ns / 1ps

// Takes the ASCII text of one decimal number, one character per item, and on the
// terminating zero character delivers the signed value times ten to the power held
// in the scale register (reset 7), saturated to +/-2147483647. One character is
// accepted every cycle unless input is held off: each item is parsed by a single
// multiply-by-ten, add and limit compare into the parse state registers, and the zero
// character loads the result register through one 31 by 30 bit multiply, so the result
// appears in the cycle after its zero character. Input is held off only while a result
// waits in the output register and the downstream side is not ready. Write the scale
// register only between numbers.
module decimal_text_to_fixed_point (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [dtfp_pkg::CHAR_W-1:0]   s_tdata,   // [7:0] character
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [dtfp_pkg::VALUE_W-1:0]  m_tdata,   // [31:0] scaled_value
	input  logic                          cfg_we,
	input  logic [dtfp_pkg::POWER_W-1:0]  cfg_wdata
);

	dtfp_pkg::parse_state_t state;
	logic                   char_fire;
	logic                   end_fire;

	// An item is taken whenever the result register is free or being emptied.
	assign s_tready  = !m_tvalid || m_tready;
	assign char_fire = s_tvalid && s_tready;
	assign end_fire  = char_fire && (s_tdata == dtfp_pkg::CH_NUL);

	dtfp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.char_fire (char_fire),
		.char_in   (s_tdata),
		.state     (state)
	);

	dtfp_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (end_fire),
		.state    (state),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

`ifndef ASSERT_OFF
	// A result only appears after a zero character was accepted.
	a_result_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(end_fire))
		else $error("result appeared without an end of number");

	// Every accepted zero character leaves a result in the output register.
	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		end_fire |=> m_tvalid)
		else $error("end of number produced no result");

	// The magnitude saturates symmetrically, so the most negative code never occurs.
	a_no_min_int: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata != 32'h8000_0000))
		else $error("result outside the saturated range");

	// With the output register empty the input side is never held off.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty result register");
`endif

endmodule
